### src/pid_trapezoid_clamped_core_assert.svh
// Assertion macros for the PID controller core checker.
// Used by pid_tc_checker.sv; depends on nothing else.
`ifndef PID_TRAPEZOID_CLAMPED_CORE_ASSERT_SVH
`define PID_TRAPEZOID_CLAMPED_CORE_ASSERT_SVH

// Property that must hold in the same cycle as its trigger.
`define PID_TC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Property that must hold in the cycle after its trigger.
`define PID_TC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/pid_tc_pkg.sv
// Package for the PID controller core: sequencer states, register indexes,
// fixed-point constants and the saturation helper. Depends on nothing.
`default_nettype none

package pid_tc_pkg;

  // Fraction bits of the Q16.16 format.
  localparam int unsigned FracBits = 16;
  // Bits of the derivative dividend: 33-bit magnitude with 16 zero bits.
  localparam int unsigned DivBits  = 33 + FracBits;
  localparam int unsigned CntBits  = $clog2(DivBits);

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_GAIN_P    = 3'd0;
  localparam logic [2:0] REG_GAIN_I    = 3'd1;
  localparam logic [2:0] REG_GAIN_D    = 3'd2;
  localparam logic [2:0] REG_OUT_MIN   = 3'd3;
  localparam logic [2:0] REG_OUT_MAX   = 3'd4;
  localparam logic [2:0] REG_INTEG_MIN = 3'd5;
  localparam logic [2:0] REG_INTEG_MAX = 3'd6;

  localparam logic signed [31:0] MaxS32 = 32'sh7fff_ffff;
  localparam logic signed [31:0] MinS32 = 32'sh8000_0000;

  // Sequencer states, one-hot.
  typedef enum logic [10:0] {
    ST_IDLE   = 11'b000_0000_0001,
    ST_MUL_P  = 11'b000_0000_0010,
    ST_MUL_KI = 11'b000_0000_0100,
    ST_KI     = 11'b000_0000_1000,
    ST_MUL_TR = 11'b000_0001_0000,
    ST_INTEG  = 11'b000_0010_0000,
    ST_DIV    = 11'b000_0100_0000,
    ST_QUO    = 11'b000_1000_0000,
    ST_MUL_D  = 11'b001_0000_0000,
    ST_DTERM  = 11'b010_0000_0000,
    ST_SUM    = 11'b100_0000_0000
  } state_e;

  // Saturate a wide signed value to 32 bits signed.
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'(MaxS32)) begin
      r = MaxS32;
    end else if (v < 66'(MinS32)) begin
      r = MinS32;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### src/pid_trapezoid_clamped_core.sv
// Top level of the PID controller core with trapezoid integrator and clamps.
// Depends on pid_tc_pkg.
`default_nettype none

// Fixed-point PID controller, Q16.16 throughout.
// Input channel: target_i, sensed_i and step_time_i with in_valid_i; the core
// raises in_stall_o from the cycle after it accepts an item until the result
// is stored, so one item is worked on at a time.
// Output channel: drive_o and clamped_o with out_valid_o; the result stays in
// an output register until taken, and the core accepts the next item while it
// waits there.
// One shared 33x33 multiplier does the four products in turn, and a restoring
// divider takes one quotient bit per cycle for the derivative term; its
// divide runs 49 steps and is skipped when step_time_i is zero. The next
// item can be taken in the cycle after the result is stored.
// If the previous result is still stalled at the end, the core waits for it.
// Reset (rst_ni low) clears the gains, limits, integrator and previous error
// to zero and empties the output register.
// Registers sit at byte addresses 4*i on the APB-style port: gain_p, gain_i,
// gain_d, out_min, out_max, integ_min, integ_max. Write them only while idle.
module pid_trapezoid_clamped_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Input channel
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [31:0] target_i,
  input  wire logic signed [31:0] sensed_i,
  input  wire logic        [31:0] step_time_i,
  // Output channel
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      drive_o,
  output logic                    clamped_o,
  // Configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic        [4:0]  paddr,
  input  wire logic        [31:0] pwdata,
  output logic             [31:0] prdata,
  output logic                    pready
);

  localparam int unsigned FB = pid_tc_pkg::FracBits;
  localparam int unsigned DB = pid_tc_pkg::DivBits;
  localparam int unsigned CB = pid_tc_pkg::CntBits;
  localparam logic [CB-1:0] LastStep = CB'(DB - 1);

  // Configuration registers
  logic signed [31:0] gain_p_q, gain_i_q, gain_d_q;
  logic signed [31:0] out_min_q, out_max_q, integ_min_q, integ_max_q;

  // Controller state
  logic signed [31:0] integ_q, integ_d;
  logic signed [31:0] last_err_q;

  // Sequencer and datapath registers
  pid_tc_pkg::state_e state_q, state_d;
  logic          [CB-1:0] cnt_q, cnt_d;
  logic signed   [31:0]   err_q, err_d;
  logic          [31:0]   dt_q, dt_d;
  logic signed   [65:0]   prod_q, prod_d;
  logic signed   [31:0]   op_q, op_d;
  logic signed   [31:0]   p_q, p_d;
  logic signed   [31:0]   dterm_q, dterm_d;
  logic          [DB-1:0] qn_q, qn_d;
  logic          [31:0]   rem_q, rem_d;
  logic                   dneg_q, dneg_d;
  logic                   out_valid_q, out_valid_d;
  logic signed   [31:0]   drive_q, drive_d;
  logic                   clamped_q, clamped_d;

  // Shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_w;

  logic               wr_en;
  logic               in_accept;
  logic               out_free;

  // Configuration port: always ready, writes on the access cycle.
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q    <= '0;
      gain_i_q    <= '0;
      gain_d_q    <= '0;
      out_min_q   <= '0;
      out_max_q   <= '0;
      integ_min_q <= '0;
      integ_max_q <= '0;
    end else if (wr_en) begin
      case (paddr[4:2])
        pid_tc_pkg::REG_GAIN_P:    gain_p_q    <= pwdata;
        pid_tc_pkg::REG_GAIN_I:    gain_i_q    <= pwdata;
        pid_tc_pkg::REG_GAIN_D:    gain_d_q    <= pwdata;
        pid_tc_pkg::REG_OUT_MIN:   out_min_q   <= pwdata;
        pid_tc_pkg::REG_OUT_MAX:   out_max_q   <= pwdata;
        pid_tc_pkg::REG_INTEG_MIN: integ_min_q <= pwdata;
        pid_tc_pkg::REG_INTEG_MAX: integ_max_q <= pwdata;
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr[4:2])
      pid_tc_pkg::REG_GAIN_P:    prdata = gain_p_q;
      pid_tc_pkg::REG_GAIN_I:    prdata = gain_i_q;
      pid_tc_pkg::REG_GAIN_D:    prdata = gain_d_q;
      pid_tc_pkg::REG_OUT_MIN:   prdata = out_min_q;
      pid_tc_pkg::REG_OUT_MAX:   prdata = out_max_q;
      pid_tc_pkg::REG_INTEG_MIN: prdata = integ_min_q;
      pid_tc_pkg::REG_INTEG_MAX: prdata = integ_max_q;
      default:                   prdata = '0;
    endcase
  end

  // Handshakes.
  assign in_stall_o  = (state_q != pid_tc_pkg::ST_IDLE);
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign out_free    = ~out_valid_q | ~out_stall_i;
  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;
  assign clamped_o   = clamped_q;

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (state_q)
      pid_tc_pkg::ST_MUL_P: begin
        mul_a = 33'(gain_p_q);
        mul_b = 33'(err_q);
      end
      pid_tc_pkg::ST_MUL_KI: begin
        mul_a = 33'(gain_i_q);
        mul_b = $signed({1'b0, dt_q});
      end
      pid_tc_pkg::ST_MUL_TR: begin
        mul_a = 33'(op_q);
        mul_b = 33'(err_q) + 33'(last_err_q);
      end
      pid_tc_pkg::ST_MUL_D: begin
        mul_a = 33'(op_q);
        mul_b = 33'(gain_d_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_w = mul_a * mul_b;

  // Sequencer and datapath.
  always_comb begin
    logic signed [32:0] diff;
    logic          [32:0] trial;
    logic                 ge;
    logic signed [31:0]   trap;
    logic signed [31:0]   base;
    logic signed [31:0]   isum;
    logic signed [33:0]   total;
    logic          [32:0] dmag;

    state_d     = state_q;
    cnt_d       = cnt_q;
    err_d       = err_q;
    dt_d        = dt_q;
    prod_d      = prod_q;
    op_d        = op_q;
    p_d         = p_q;
    dterm_d     = dterm_q;
    qn_d        = qn_q;
    rem_d       = rem_q;
    dneg_d      = dneg_q;
    integ_d     = integ_q;
    out_valid_d = out_valid_q;
    drive_d     = drive_q;
    clamped_d   = clamped_q;

    diff  = '0;
    trial = '0;
    ge    = 1'b0;
    trap  = '0;
    base  = '0;
    isum  = '0;
    total = '0;
    dmag  = '0;

    // The output register empties when its item is taken.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      pid_tc_pkg::ST_IDLE: begin
        // Take an item and form the saturated error.
        if (in_accept) begin
          err_d   = pid_tc_pkg::sat32(66'(target_i) - 66'(sensed_i));
          dt_d    = step_time_i;
          state_d = pid_tc_pkg::ST_MUL_P;
        end
      end
      pid_tc_pkg::ST_MUL_P: begin
        prod_d  = prod_w;
        state_d = pid_tc_pkg::ST_MUL_KI;
      end
      pid_tc_pkg::ST_MUL_KI: begin
        p_d     = pid_tc_pkg::sat32(prod_q >>> FB);
        prod_d  = prod_w;
        state_d = pid_tc_pkg::ST_KI;
      end
      pid_tc_pkg::ST_KI: begin
        op_d    = pid_tc_pkg::sat32(prod_q >>> FB);
        state_d = pid_tc_pkg::ST_MUL_TR;
      end
      pid_tc_pkg::ST_MUL_TR: begin
        prod_d  = prod_w;
        state_d = pid_tc_pkg::ST_INTEG;
      end
      pid_tc_pkg::ST_INTEG: begin
        // Anti-windup: clear the integrator when it opposes the error.
        trap = pid_tc_pkg::sat32(prod_q >>> (FB + 1));
        if ((err_q < 0 && integ_q > 0) || (err_q > 0 && integ_q < 0)) begin
          base = '0;
        end else begin
          base = integ_q;
        end
        isum = pid_tc_pkg::sat32(66'(base) + 66'(trap));
        if (isum > integ_max_q) begin
          integ_d = integ_max_q;
        end else if (isum < integ_min_q) begin
          integ_d = integ_min_q;
        end else begin
          integ_d = isum;
        end
        // Set up the derivative divide, or skip it for a zero time step.
        diff   = 33'(err_q) - 33'(last_err_q);
        dmag   = diff[32] ? 33'(-diff) : 33'(diff);
        dneg_d = diff[32];
        qn_d   = {dmag, {FB{1'b0}}};
        rem_d  = '0;
        cnt_d  = '0;
        if (dt_q == '0) begin
          dterm_d = '0;
          state_d = pid_tc_pkg::ST_SUM;
        end else begin
          state_d = pid_tc_pkg::ST_DIV;
        end
      end
      pid_tc_pkg::ST_DIV: begin
        // One restoring step: quotient bits shift in at the bottom.
        trial = {rem_q, qn_q[DB-1]};
        ge    = (trial >= {1'b0, dt_q});
        if (ge) begin
          rem_d = 32'(trial - {1'b0, dt_q});
        end else begin
          rem_d = trial[31:0];
        end
        qn_d  = {qn_q[DB-2:0], ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LastStep) begin
          state_d = pid_tc_pkg::ST_QUO;
        end
      end
      pid_tc_pkg::ST_QUO: begin
        // Apply the sign and saturate the quotient.
        if (dneg_q) begin
          if (qn_q > DB'(33'h0_8000_0000)) begin
            op_d = pid_tc_pkg::MinS32;
          end else begin
            op_d = 32'(-qn_q);
          end
        end else begin
          if (qn_q > DB'(pid_tc_pkg::MaxS32)) begin
            op_d = pid_tc_pkg::MaxS32;
          end else begin
            op_d = qn_q[31:0];
          end
        end
        state_d = pid_tc_pkg::ST_MUL_D;
      end
      pid_tc_pkg::ST_MUL_D: begin
        prod_d  = prod_w;
        state_d = pid_tc_pkg::ST_DTERM;
      end
      pid_tc_pkg::ST_DTERM: begin
        dterm_d = pid_tc_pkg::sat32(prod_q >>> FB);
        state_d = pid_tc_pkg::ST_SUM;
      end
      pid_tc_pkg::ST_SUM: begin
        // Sum the terms exactly, clamp, and load the output register.
        if (out_free) begin
          total = 34'(p_q) + 34'(integ_q) + 34'(dterm_q);
          if (total > 34'(out_max_q)) begin
            drive_d   = out_max_q;
            clamped_d = 1'b1;
          end else if (total < 34'(out_min_q)) begin
            drive_d   = out_min_q;
            clamped_d = 1'b1;
          end else begin
            drive_d   = total[31:0];
            clamped_d = 1'b0;
          end
          out_valid_d = 1'b1;
          state_d     = pid_tc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pid_tc_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state and controller memory.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pid_tc_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      integ_q     <= '0;
      last_err_q  <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      integ_q     <= integ_d;
      if (state_q == pid_tc_pkg::ST_SUM && out_free) begin
        last_err_q <= err_q;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    err_q     <= err_d;
    dt_q      <= dt_d;
    prod_q    <= prod_d;
    op_q      <= op_d;
    p_q       <= p_d;
    dterm_q   <= dterm_d;
    qn_q      <= qn_d;
    rem_q     <= rem_d;
    dneg_q    <= dneg_d;
    drive_q   <= drive_d;
    clamped_q <= clamped_d;
  end

endmodule

`default_nettype wire

### src/pid_tc_checker.sv
// Port-level checker for the PID controller core, bound to the top level.
// Depends on pid_trapezoid_clamped_core_assert.svh.
`default_nettype none

`include "pid_trapezoid_clamped_core_assert.svh"

module pid_tc_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic signed [31:0] drive_o,
  input wire logic               clamped_o
);

  // A stalled result stays offered and unchanged.
  `PID_TC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")
  `PID_TC_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(drive_o) && $stable(clamped_o), "stalled result changed")

  // The core is busy right after it takes an item, and no result follows at once.
  `PID_TC_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o && !$rose(out_valid_o), "core not busy after accept")

  // With no item in progress, a taken result leaves the output empty.
  `PID_TC_ASSERT_NEXT(a_no_phantom, clk_i, rst_ni, out_valid_o && !out_stall_i && !in_stall_o, !out_valid_o, "result appeared without an item")

endmodule

bind pid_trapezoid_clamped_core pid_tc_checker u_pid_tc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .drive_o     (drive_o),
  .clamped_o   (clamped_o)
);

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 100ps
// Testbench for pid_trapezoid_clamped_core: drives random and corner-case items,
// predicts every drive value in a scoreboard class and checks each result in order.
// Depends on pid_tc_pkg and pid_trapezoid_clamped_core.

module tb;
  import pid_tc_pkg::*;

  localparam int unsigned StallLimit = 3000;
  localparam int unsigned ItemsPerPhase = 50;
  localparam int unsigned PhaseCount = 15;
  localparam logic [2:0] RegSpare = 3'd7;

  localparam logic signed [31:0] One      = 32'sh0001_0000;
  localparam logic signed [31:0] Half     = 32'sh0000_8000;
  localparam logic signed [31:0] Quarter  = 32'sh0000_4000;
  localparam logic signed [31:0] Hundred  = 32'sh0064_0000;
  localparam logic signed [31:0] Thousand = 32'sh03e8_0000;

  typedef struct {
    logic signed [31:0] drive;
    logic               clamped;
  } drive_item_t;

  // Tracks the controller state and the queue of drive values still owed.
  class drive_ledger;
    logic signed [31:0] kp, ki, kd, out_lo, out_hi, integ_lo, integ_hi;
    logic signed [31:0] integ_acc, prev_err;
    drive_item_t        owed_q[$];
    int                 errors;

    function new();
      kp = '0; ki = '0; kd = '0;
      out_lo = '0; out_hi = '0; integ_lo = '0; integ_hi = '0;
      integ_acc = '0; prev_err = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
        REG_GAIN_P:    kp = value;
        REG_GAIN_I:    ki = value;
        REG_GAIN_D:    kd = value;
        REG_OUT_MIN:   out_lo = value;
        REG_OUT_MAX:   out_hi = value;
        REG_INTEG_MIN: integ_lo = value;
        REG_INTEG_MAX: integ_hi = value;
        default: ;
      endcase
    endfunction

    function logic signed [31:0] clip32(logic signed [127:0] v);
      if (v > MaxS32) return MaxS32;
      if (v < MinS32) return MinS32;
      return v[31:0];
    endfunction

    // Exact product, floor shift, then saturation.
    function logic signed [31:0] qmul(logic signed [127:0] a, logic signed [127:0] b,
                                      int unsigned sh);
      logic signed [127:0] prod;
      prod = a * b;
      return clip32(prod >>> sh);
    endfunction

    // One controller step: updates the integrator and previous error.
    function drive_item_t compute_drive(logic signed [31:0] target, logic signed [31:0] sensed,
                                        logic [31:0] step);
      logic signed [127:0] t_w, s_w, dt_w, err_w, last_w, acc_w, p_term, d_term, sum;
      logic signed [31:0]  err, ki_dt, trap, quo;
      drive_item_t         r;
      t_w = target;
      s_w = sensed;
      dt_w = {96'd0, step};
      err = clip32(t_w - s_w);
      err_w = err;
      last_w = prev_err;
      p_term = qmul(kp, err_w, 16);

      // Anti-windup: drop an integrator that pulls against the error.
      if ((err < 0 && integ_acc > 0) || (err > 0 && integ_acc < 0)) integ_acc = '0;
      ki_dt = qmul(ki, dt_w, 16);
      trap = qmul(ki_dt, err_w + last_w, 17);
      acc_w = integ_acc;
      acc_w = acc_w + trap;
      integ_acc = clip32(acc_w);
      if (integ_acc > integ_hi) begin
        integ_acc = integ_hi;
      end else if (integ_acc < integ_lo) begin
        integ_acc = integ_lo;
      end

      // Derivative with a truncating divide; a zero step disables it.
      if (step == 0) begin
        d_term = 0;
      end else begin
        quo = clip32(((err_w - last_w) * 65536) / dt_w);
        d_term = qmul(quo, kd, 16);
      end

      sum = p_term + integ_acc + d_term;
      r.clamped = 1'b0;
      if (sum > out_hi) begin
        r.drive = out_hi;
        r.clamped = 1'b1;
      end else if (sum < out_lo) begin
        r.drive = out_lo;
        r.clamped = 1'b1;
      end else begin
        r.drive = sum[31:0];
      end
      prev_err = err;
      return r;
    endfunction

    function void note_sample(logic signed [31:0] target, logic signed [31:0] sensed,
                              logic [31:0] step);
      owed_q.push_back(compute_drive(target, sensed, step));
    endfunction

    function void check_drive(logic signed [31:0] drive, logic clamped);
      drive_item_t want;
      if (owed_q.size() == 0) begin
        $error("result with nothing owed: drive=%0d clamped=%0b", drive, clamped);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (drive !== want.drive) begin
        $error("field drive: expected %0d, got %0d", want.drive, drive);
        errors++;
      end
      if (clamped !== want.clamped) begin
        $error("field clamped: expected %0b, got %0b", want.clamped, clamped);
        errors++;
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [31:0] target_i = '0;
  logic signed [31:0] sensed_i = '0;
  logic        [31:0] step_time_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] drive_o;
  logic               clamped_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic        [4:0]  paddr = '0;
  logic        [31:0] pwdata = '0;
  logic        [31:0] prdata;
  logic               pready;

  drive_ledger sb;
  bit          calm = 1'b0;
  int          hold_cycles = 0;
  int unsigned quiet_cycles = 0;

  pid_trapezoid_clamped_core dut (.*);

  always #10 clk_i = ~clk_i;

  // Receiver: random stalls, a long hold-off on request, none while calm.
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < 15);
    end
  end

  // Every accepted result is checked against the oldest owed item.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_drive(drive_o, clamped_o);
  end

  // Watchdog on cycles with no item moving on either channel.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("tb: FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, value);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic write_gains(input logic [31:0] p, input logic [31:0] i, input logic [31:0] d,
                             input logic [31:0] omin, input logic [31:0] omax,
                             input logic [31:0] imin, input logic [31:0] imax);
    write_reg(REG_GAIN_P, p);
    write_reg(REG_GAIN_I, i);
    write_reg(REG_GAIN_D, d);
    write_reg(REG_OUT_MIN, omin);
    write_reg(REG_OUT_MAX, omax);
    write_reg(REG_INTEG_MIN, imin);
    write_reg(REG_INTEG_MAX, imax);
  endtask

  // Offers one item, with an occasional gap first, and waits for acceptance.
  task automatic send_item(input logic signed [31:0] target, input logic signed [31:0] sensed,
                           input logic [31:0] step);
    int gap;
    @(negedge clk_i);
    if (!calm && $urandom_range(99) < 15) begin
      gap = $urandom_range(1, ($urandom_range(3) == 0) ? 70 : 6);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    target_i <= target;
    sensed_i <= sensed;
    step_time_i <= step;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_sample(target, sensed, step);
  endtask

  // Drops valid and waits until every owed result has come back.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_level();
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
      6: return $urandom;
      7: return MaxS32;
      8: return MinS32;
      default: return '0;
    endcase
  endfunction

  function automatic logic [31:0] pick_step();
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return $urandom_range(32'h100, 32'h1_0000);
      6: return $urandom;
      7: return '0;
      8: return 32'hffff_ffff;
      default: return $urandom_range(1, 255);
    endcase
  endfunction

  function automatic logic [31:0] pick_gain();
    return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
  endfunction

  function automatic logic [31:0] pick_corner();
    case ($urandom_range(3))
      0: return MaxS32;
      1: return MinS32;
      2: return '0;
      default: return $urandom;
    endcase
  endfunction

  // Loads one of several register settings: moderate, random, extreme or crossed.
  task automatic random_setup(input int kind);
    logic [31:0] out_lim, integ_lim;
    out_lim = $urandom_range(0, 32'h0800_0000);
    integ_lim = $urandom_range(0, 32'h0400_0000);
    case (kind)
      0: write_gains(pick_gain(), pick_gain(), pick_gain(), -out_lim, out_lim,
                     -integ_lim, integ_lim);
      1: write_gains($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      2: write_gains(pick_corner(), pick_corner(), pick_corner(), MinS32, MaxS32,
                     MinS32, MaxS32);
      default: write_gains(pick_gain(), pick_gain(), pick_gain(), out_lim, -out_lim,
                           integ_lim, -integ_lim);
    endcase
    if ($urandom_range(2) == 0) write_reg(RegSpare, $urandom);
  endtask

  initial begin
    sb = new();
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: ordinary gains, then saturation, zero and tiny steps, sign flips.
    write_gains(One, Half, Quarter, -Thousand, Thousand, -Hundred, Hundred);
    write_reg(RegSpare, 32'hdead_beef);
    send_item(One, 0, One);
    send_item(One, 0, 0);
    send_item(3 * One, One, 32'h0000_8000);
    send_item(-5 * One, 0, One);
    send_item(0, 0, 0);
    send_item(MaxS32, MinS32, One);
    send_item(MinS32, MaxS32, One);
    send_item(0, 0, 32'd1);
    send_item(-2 * One, 0, 32'hffff_ffff);
    send_item(MaxS32, 0, 0);
    send_item(0, MaxS32, 2 * One);
    send_item(32'sd1, -32'sd1, One);

    // Largest gains with the widest output and integrator limits.
    settle();
    write_gains(MaxS32, MaxS32, MaxS32, MinS32, MaxS32, MinS32, MaxS32);
    send_item(One, 0, One);
    send_item(MinS32, MaxS32, 32'd1);
    send_item(MaxS32, MinS32, 32'hffff_ffff);

    // Most negative gains.
    settle();
    write_gains(MinS32, MinS32, MinS32, MinS32, MaxS32, MinS32, MaxS32);
    send_item(One, 0, One);
    send_item(MinS32, MaxS32, 32'd1);
    send_item(MaxS32, MinS32, 32'hffff_ffff);

    // Crossed output and integrator limits.
    settle();
    write_gains(One, One, One, Thousand, -Thousand, Hundred, -Hundred);
    send_item(One, 0, One);
    send_item(-One, 0, One);
    send_item(0, 0, 0);

    // Random phases, one with no idling and one with a long receiver hold-off.
    for (int ph = 0; ph < PhaseCount; ph++) begin
      settle();
      random_setup(ph % 4);
      calm = (ph == 4);
      if (ph == 7) hold_cycles = 400;
      for (int k = 0; k < ItemsPerPhase; k++) begin
        send_item(pick_level(), pick_level(), pick_step());
      end
    end
    calm = 1'b0;

    settle();
    repeat (80) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/pid_tc_pkg.sv
src/pid_trapezoid_clamped_core.sv
src/pid_tc_checker.sv
tb/sv/tb.sv
